FILE: hdl/fplsu_pkg.sv
// Package: shared types, codes and float conversion helpers for the FP load/store unit.
`default_nettype none
package fplsu_pkg;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FP_UNAV = 2'd1,
    ST_FAULT   = 2'd2
  } status_t;

  localparam logic [4:0] KIND_LFD    = 5'd0;
  localparam logic [4:0] KIND_LFS    = 5'd4;
  localparam logic [4:0] KIND_STFD   = 5'd8;
  localparam logic [4:0] KIND_STFIWX = 5'd12;
  localparam logic [4:0] KIND_STFS   = 5'd13;
  localparam logic [4:0] KIND_LAST   = 5'd16;

  localparam logic [0:0] CFG_FP_ENABLED = 1'd0;
  localparam logic [0:0] CFG_PS_ENABLE  = 1'd1;

  localparam logic [63:0] LOW_WORD_MASK = 64'h0000_0000_ffff_ffff;

  typedef struct packed {
    logic [4:0]         kind;
    logic [4:0]         ra_index;
    logic [31:0]        ra_value;
    logic [31:0]        rb_value;
    logic signed [15:0] displacement;
    logic [63:0]        source_bits;
    logic [63:0]        load_data;
    logic               access_fault;
  } req_t;

  typedef struct packed {
    logic [31:0] address;
    logic        access_double;
    logic        is_store;
    logic [63:0] store_data;
    logic        fpr_write;
    logic [63:0] ps0_bits;
    logic        ps1_write;
    logic [63:0] ps1_bits;
    logic        gpr_write;
    logic [31:0] gpr_value;
    logic [1:0]  status;
    logic        pc_advance;
  } rsp_t;

  typedef struct packed {
    logic legal;
    logic update;
    logic indexed;
    logic store;
    logic dbl;
    logic single;
    logic raw_word;
  } dec_t;

  function automatic dec_t decode(input logic [4:0] kind);
    dec_t d;
    logic [1:0] form;
    d = '0;
    form = kind[1:0];
    if (kind >= KIND_STFS) form = 2'(kind - KIND_STFS);
    if (kind == KIND_STFIWX) form = 2'd3;
    d.legal    = kind <= KIND_LAST;
    d.update   = (form == 2'd1) || (form == 2'd2);
    d.indexed  = (form == 2'd2) || (form == 2'd3);
    d.store    = kind >= KIND_STFD;
    d.dbl      = (kind < KIND_LFS) || (kind >= KIND_STFD && kind < KIND_STFIWX);
    d.single   = (kind >= KIND_LFS) && (kind < KIND_STFD);
    d.raw_word = kind == KIND_STFIWX;
    return d;
  endfunction

  function automatic logic [63:0] widen_single(input logic [31:0] w);
    logic [7:0]  e;
    logic [22:0] m;
    logic [22:0] mn;
    logic [4:0]  lz;
    logic [10:0] ex;
    logic        found;
    e = w[30:23];
    m = w[22:0];
    lz = '0;
    found = 1'b0;
    for (int i = 22; i >= 0; i--) begin
      if (!found && m[i]) begin
        found = 1'b1;
        lz = 5'(22 - i);
      end
    end
    mn = 23'(m << (lz + 5'd1));
    ex = 11'd896 - 11'(lz);
    if (e == 8'hff) return {w[31], 11'h7ff, m, 29'd0};
    if (e == 8'd0) begin
      if (m == '0) return {w[31], 63'd0};
      return {w[31], ex, mn, 29'd0};
    end
    return {w[31], 11'(e) + 11'd896, m, 29'd0};
  endfunction

  function automatic logic [31:0] narrow_double(input logic [63:0] d);
    logic [10:0] e;
    logic [51:0] m;
    logic signed [12:0] es;
    logic [63:0] full;
    logic [5:0]  sh;
    logic [63:0] q;
    logic [63:0] rem;
    logic [63:0] half;
    logic [31:0] r;
    e = d[62:52];
    m = d[51:0];
    es = 13'(e) - 13'sd896;
    full = {11'd0, 1'b1, m};
    sh = (es >= 1) ? 6'd29 : 6'(13'sd30 - es);
    q = full >> sh;
    rem = full & ((64'd1 << sh) - 64'd1);
    half = 64'd1 << (sh - 6'd1);
    if (rem > half || (rem == half && q[0])) q = q + 64'd1;
    if (e == 11'h7ff) begin
      if (m != '0) return {d[63], 8'hff, 1'b1, m[50:29]};
      return {d[63], 31'h7f800000};
    end
    if (e == 11'd0) return {d[63], 31'd0};
    if (es >= 255) return {d[63], 31'h7f800000};
    if (es < -13'sd30) return {d[63], 31'd0};
    if (es >= 1) begin
      r = {9'(es - 13'sd1), 23'd0} + 32'(q);
      if (r >= 32'h7f800000) r = 32'h7f800000;
      return {d[63], r[30:0]};
    end
    return {d[63], q[30:0]};
  endfunction

endpackage
`default_nettype wire

FILE: hdl/fplsu_exec.sv
// Execute logic: address generation, data conversion and result assembly.
`default_nettype none
module fplsu_exec (
  input  var fplsu_pkg::req_t req,
  input  var logic            fp_enabled,
  input  var logic            paired_single_enable,
  output fplsu_pkg::rsp_t     rsp
);
  import fplsu_pkg::*;

  dec_t        d;
  logic [31:0] base;
  logic [31:0] ea;
  logic [63:0] v;

  always_comb begin
    d = decode(req.kind);
    base = (d.update || req.ra_index != '0) ? req.ra_value : '0;
    ea = base + (d.indexed ? req.rb_value : 32'(req.displacement));
    v = d.single ? widen_single(req.load_data[31:0]) : req.load_data;
    rsp = '0;
    if (!d.legal) begin
      rsp = '0;
    end else if (!fp_enabled) begin
      rsp.status = ST_FP_UNAV;
    end else begin
      rsp.address = ea;
      rsp.access_double = d.dbl;
      rsp.is_store = d.store;
      if (d.store) begin
        if (d.dbl) rsp.store_data = req.source_bits;
        else if (d.raw_word) rsp.store_data = req.source_bits & LOW_WORD_MASK;
        else rsp.store_data = {32'd0, narrow_double(req.source_bits)};
      end
      if (req.access_fault) begin
        rsp.status = ST_FAULT;
      end else begin
        if (!d.store) begin
          rsp.fpr_write = 1'b1;
          rsp.ps0_bits = v;
          if (d.single && paired_single_enable) begin
            rsp.ps1_write = 1'b1;
            rsp.ps1_bits = v;
          end
        end
        if (d.update) begin
          rsp.gpr_write = 1'b1;
          rsp.gpr_value = ea;
        end
        rsp.pc_advance = 1'b1;
      end
    end
  end
endmodule
`default_nettype wire

FILE: hdl/fp_load_store_unit_core.sv
// Top level: input register, execute logic, result register with skid slot.
// Throughput: one request per cycle unless stalled; execute is single-pass.
// A skid slot keeps in_ready high the cycle the result stalls.
// Reset: synchronous; clears valids, fp_enabled and paired_single_enable.
`default_nettype none
module fp_load_store_unit_core (
  input  var logic             clk,
  input  var logic             rst,
  input  var logic             in_valid,
  output logic                 in_ready,
  input  var fplsu_pkg::req_t  in_data,
  output logic                 out_valid,
  input  var logic             out_ready,
  output fplsu_pkg::rsp_t      out_data,
  input  var logic             cfg_we,
  input  var logic [0:0]       cfg_index,
  input  var logic [0:0]       cfg_wdata
);
  import fplsu_pkg::*;

  logic fp_enabled;
  logic paired_single_enable;
  logic req_valid;
  req_t req;
  rsp_t rsp;
  logic skid_valid;
  rsp_t skid;

  fplsu_exec u_exec (
    .req                  (req),
    .fp_enabled           (fp_enabled),
    .paired_single_enable (paired_single_enable),
    .rsp                  (rsp)
  );

  logic advance;
  assign advance = !out_valid || out_ready;
  assign in_ready = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      fp_enabled <= 1'b0;
      paired_single_enable <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FP_ENABLED: fp_enabled <= cfg_wdata[0];
        CFG_PS_ENABLE:  paired_single_enable <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
      out_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (advance) begin
        if (skid_valid) begin
          out_valid <= 1'b1;
          out_data <= skid;
          skid_valid <= 1'b0;
        end else begin
          out_valid <= req_valid;
          out_data <= rsp;
        end
      end else if (req_valid && !skid_valid) begin
        skid_valid <= 1'b1;
        skid <= rsp;
      end
      if (in_ready) begin
        req_valid <= in_valid;
        req <= in_data;
      end
    end
  end
endmodule
`default_nettype wire

FILE: hdl/fplsu_checker.sv
// Checker: port-level assertions for the FP load/store unit, with bind.
`default_nettype none
module fplsu_checker (
  input var logic            clk,
  input var logic            rst,
  input var logic            in_ready,
  input var logic            out_valid,
  input var logic            out_ready,
  input var fplsu_pkg::rsp_t out_data
);
  import fplsu_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");
  a_fault: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status == ST_FAULT |->
      !out_data.fpr_write && !out_data.gpr_write && !out_data.pc_advance)
    else $error("fault with writeback");
  a_ps1: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.ps1_write |-> out_data.fpr_write && !out_data.access_double)
    else $error("ps1 write without single load");
  a_unav: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status == ST_FP_UNAV |-> out_data.address == '0)
    else $error("unavailable result carries address");
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");
endmodule

bind fp_load_store_unit_core fplsu_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
`default_nettype wire
